@@ rtl/text_window_character_writer_macros.svh @@
// Assertion macros shared by the text window writer modules.
// Checks are sampled on rising clk; TWCW_ASSERT holds off while rst_n is low.
`ifndef TEXT_WINDOW_CHARACTER_WRITER_MACROS_SVH
`define TEXT_WINDOW_CHARACTER_WRITER_MACROS_SVH

`ifndef SYNTHESIS

// Check a property while the block is out of reset.
`define TWCW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define TWCW_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TWCW_ASSERT(lbl, prop, msg)
`define TWCW_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ rtl/twcw_pkg.sv @@
package twcw_pkg;

    // Store geometry: cell (r,c) lives at r*MAX_COLS+c.
    localparam int MAX_COLS  = 80;
    localparam int MAX_ROWS  = 32;
    localparam int ROW_LIMIT = 32;
    localparam int DEPTH     = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W    = $clog2(DEPTH);

    // Usable window size limits, held to the widths of the size registers.
    localparam int COL_CAP = (MAX_COLS < 127) ? MAX_COLS : 127;
    localparam int ROW_CAP = (MAX_ROWS < ROW_LIMIT) ? MAX_ROWS : ROW_LIMIT;

    // Character and color codes.
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] RESET_COLOR  = 8'h0F;

    // Operation codes.
    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_COLS  = 2'd0,
        CFG_ROWS  = 2'd1,
        CFG_COLOR = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] character;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } in_item_t;

    typedef struct packed {
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic        scrolled;
        logic [15:0] cell_data;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_FLUSH,
        ST_CLEAR
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
        logic scan_step;
        logic fill_step;
        logic fill_reset;
        logic emit;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] op;
        logic       need_scroll;
        logic       scan_last;
        logic       fill_last;
    } ctrl_status_t;

    // Linear store address of a cell.
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [5:0] row,
                                                     input logic [6:0] col);
        logic [ADDR_W+7:0] full;
        full = (ADDR_W+8)'(row) * (ADDR_W+8)'(MAX_COLS) + (ADDR_W+8)'(col);
        return full[ADDR_W-1:0];
    endfunction

endpackage

@@ rtl/text_window_character_writer.sv @@
// Text window writer: a grid of character cells with a cursor. An item is
// taken when start is high and busy is low; its result appears on the result
// ports for exactly one cycle while done is high, and the receiver cannot hold
// it off, so it must be captured in that cycle. A put without a scroll, a read
// and the unused operation go from idle through the execute state back to
// idle, and done is registered from the execute state. A put that scrolls
// walks the store through its single write port one cell a cycle, then passes
// the flush state. A clear writes every one of the 2560 cells. After reset the
// block fills the store with blanks, which keeps busy high until the fill is
// done; configuration writes are taken at any time and should only be made
// while the block is idle.
module text_window_character_writer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  twcw_pkg::in_item_t  request,
    output twcw_pkg::out_item_t result,
    output logic                done,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data
);

    twcw_pkg::ctrl_cmd_t    cmd;
    twcw_pkg::ctrl_status_t status;

    // Sequencer for operations, scroll and fill passes.
    twcw_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Cell store, cursor and configuration.
    twcw_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .request   (request),
        .result    (result),
        .done      (done),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

@@ rtl/twcw_ctrl.sv @@
`include "text_window_character_writer_macros.svh"

module twcw_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  twcw_pkg::ctrl_status_t  status,
    output twcw_pkg::ctrl_cmd_t     cmd,
    output logic                    busy
);

    twcw_pkg::state_t state_reg;
    twcw_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= twcw_pkg::ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            twcw_pkg::ST_INIT:
            begin
                if (status.fill_last)
                begin
                    state_next = twcw_pkg::ST_IDLE;
                end
            end
            twcw_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = twcw_pkg::ST_EXEC;
                end
            end
            twcw_pkg::ST_EXEC:
            begin
                case (status.op)
                    twcw_pkg::OP_PUT:
                    begin
                        state_next = status.need_scroll ? twcw_pkg::ST_SCROLL
                                                        : twcw_pkg::ST_IDLE;
                    end
                    twcw_pkg::OP_CLEAR: state_next = twcw_pkg::ST_CLEAR;
                    default:            state_next = twcw_pkg::ST_IDLE;
                endcase
            end
            twcw_pkg::ST_SCROLL:
            begin
                if (status.scan_last)
                begin
                    state_next = twcw_pkg::ST_FLUSH;
                end
            end
            twcw_pkg::ST_FLUSH: state_next = twcw_pkg::ST_IDLE;
            twcw_pkg::ST_CLEAR:
            begin
                if (status.fill_last)
                begin
                    state_next = twcw_pkg::ST_IDLE;
                end
            end
            default: state_next = twcw_pkg::ST_INIT;
        endcase
    end

    // Commands for the datapath.
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            twcw_pkg::ST_INIT:
            begin
                cmd.fill_step  = 1'b1;
                cmd.fill_reset = 1'b1;
            end
            twcw_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            twcw_pkg::ST_EXEC:
            begin
                cmd.exec = 1'b1;
                case (status.op)
                    twcw_pkg::OP_PUT:   cmd.emit = !status.need_scroll;
                    twcw_pkg::OP_CLEAR: cmd.emit = 1'b0;
                    default:            cmd.emit = 1'b1;
                endcase
            end
            twcw_pkg::ST_SCROLL: cmd.scan_step = 1'b1;
            twcw_pkg::ST_FLUSH:  cmd.emit = 1'b1;
            twcw_pkg::ST_CLEAR:
            begin
                cmd.fill_step = 1'b1;
                cmd.emit      = status.fill_last;
            end
            default: cmd = '0;
        endcase
    end

    // An accepted item always moves on to execution.
    `TWCW_ASSERT(a_accept_to_exec, (start && !busy) |=> (state_reg == twcw_pkg::ST_EXEC), "accepted item did not reach execution")
    // A result is only produced at the end of an operation.
    `TWCW_ASSERT(a_emit_state, cmd.emit |-> (state_reg == twcw_pkg::ST_EXEC || state_reg == twcw_pkg::ST_FLUSH || state_reg == twcw_pkg::ST_CLEAR), "result produced outside an ending state")

endmodule

@@ rtl/twcw_datapath.sv @@
`include "text_window_character_writer_macros.svh"

module twcw_datapath (
    input  logic                    clk,
    input  logic                    rst_n,
    input  twcw_pkg::ctrl_cmd_t     cmd,
    output twcw_pkg::ctrl_status_t  status,
    input  twcw_pkg::in_item_t      request,
    output twcw_pkg::out_item_t     result,
    output logic                    done,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [1:0]              cfg_index,
    input  logic [7:0]              cfg_data
);

    localparam logic [twcw_pkg::ADDR_W-1:0] LAST_ADDR = twcw_pkg::ADDR_W'(twcw_pkg::DEPTH - 1);

    // Cell store with one write port and one registered read port.
    logic [15:0] mem [twcw_pkg::DEPTH];
    logic                        mem_we;
    logic [twcw_pkg::ADDR_W-1:0] mem_waddr;
    logic [15:0]                 mem_wdata;
    logic [twcw_pkg::ADDR_W-1:0] mem_raddr;
    logic [15:0]                 rdata_reg;

    // Configuration and cursor state.
    logic [6:0] content_cols_reg;
    logic [5:0] content_rows_reg;
    logic [7:0] text_color_reg;
    logic [4:0] cursor_row_reg, cursor_row_next;
    logic [6:0] cursor_col_reg, cursor_col_next;

    // Item and result registers.
    twcw_pkg::in_item_t item_reg;
    logic        scrolled_reg, scrolled_next;
    logic [15:0] data_reg, data_next;
    logic        done_reg;

    // Scroll walker and fill counter.
    logic [5:0] scan_row_reg, scan_row_next;
    logic [6:0] scan_col_reg, scan_col_next;
    logic                        wr_pend_reg;
    logic                        wr_blank_reg;
    logic [twcw_pkg::ADDR_W-1:0] wr_dest_reg;
    logic [twcw_pkg::ADDR_W-1:0] fill_cnt_reg, fill_cnt_next;

    // Put evaluation signals.
    logic [6:0]  cols_c;
    logic [5:0]  rows_c;
    logic [4:0]  r0;
    logic [6:0]  c0;
    logic [5:0]  r1;
    logic [6:0]  c1;
    logic [6:0]  c_inc;
    logic        put_we;
    logic [twcw_pkg::ADDR_W-1:0] put_addr;
    logic [15:0] put_cell;
    logic        need_scroll;
    logic [15:0] blank_cell;
    logic        read_in_range;
    logic        scan_last;
    logic        fill_last;

    assign cfg_ready  = 1'b1;
    assign blank_cell = {text_color_reg, twcw_pkg::CH_SPACE};

    // Usable window size from the size registers.
    always_comb
    begin
        if (content_cols_reg == 7'd0)
        begin
            cols_c = 7'd1;
        end
        else if (content_cols_reg > 7'(twcw_pkg::COL_CAP))
        begin
            cols_c = 7'(twcw_pkg::COL_CAP);
        end
        else
        begin
            cols_c = content_cols_reg;
        end
        if (content_rows_reg == 6'd0)
        begin
            rows_c = 6'd1;
        end
        else if (content_rows_reg > 6'(twcw_pkg::ROW_CAP))
        begin
            rows_c = 6'(twcw_pkg::ROW_CAP);
        end
        else
        begin
            rows_c = content_rows_reg;
        end
    end

    // Put of one character: cursor pull-back, edit and wrap.
    always_comb
    begin
        r0 = ({1'b0, cursor_row_reg} >= rows_c) ? 5'(rows_c - 6'd1) : cursor_row_reg;
        c0 = (cursor_col_reg >= cols_c) ? (cols_c - 7'd1) : cursor_col_reg;
        c_inc    = c0 + 7'd1;
        r1       = {1'b0, r0};
        c1       = c0;
        put_we   = 1'b0;
        put_addr = twcw_pkg::cell_addr({1'b0, r0}, c0);
        put_cell = 16'd0;
        if (item_reg.character == twcw_pkg::CH_NEWLINE)
        begin
            c1 = 7'd0;
            r1 = {1'b0, r0} + 6'd1;
        end
        else if (item_reg.character == twcw_pkg::CH_BACKSPACE)
        begin
            if (c0 != 7'd0)
            begin
                c1       = c0 - 7'd1;
                put_we   = 1'b1;
                put_addr = twcw_pkg::cell_addr({1'b0, r0}, c0 - 7'd1);
                put_cell = blank_cell;
            end
        end
        else
        begin
            put_we   = 1'b1;
            put_cell = {text_color_reg, item_reg.character};
            if (c_inc >= cols_c)
            begin
                c1 = 7'd0;
                r1 = {1'b0, r0} + 6'd1;
            end
            else
            begin
                c1 = c_inc;
            end
        end
        need_scroll = (r1 >= rows_c);
    end

    assign read_in_range = (32'(item_reg.read_row) < 32'(twcw_pkg::MAX_ROWS)) &&
                           (32'(item_reg.read_col) < 32'(twcw_pkg::MAX_COLS));

    // Next cursor and result fields at execution.
    always_comb
    begin
        cursor_row_next = cursor_row_reg;
        cursor_col_next = cursor_col_reg;
        scrolled_next   = scrolled_reg;
        data_next       = data_reg;
        if (cmd.exec)
        begin
            scrolled_next = 1'b0;
            data_next     = 16'd0;
            case (item_reg.operation)
                twcw_pkg::OP_PUT:
                begin
                    cursor_col_next = c1;
                    cursor_row_next = need_scroll ? 5'(rows_c - 6'd1) : r1[4:0];
                    scrolled_next   = need_scroll;
                    data_next       = put_cell;
                end
                twcw_pkg::OP_READ:
                begin
                    data_next = read_in_range ? rdata_reg : 16'd0;
                end
                twcw_pkg::OP_CLEAR:
                begin
                    cursor_row_next = 5'd0;
                    cursor_col_next = 7'd0;
                end
                default:
                begin
                    data_next = 16'd0;
                end
            endcase
        end
    end

    // Scroll walker: source rows 1 to rows-1, then the bottom row as blanks.
    assign scan_last = (scan_row_reg == rows_c) && (scan_col_reg == cols_c - 7'd1);

    always_comb
    begin
        scan_row_next = scan_row_reg;
        scan_col_next = scan_col_reg;
        if (cmd.exec)
        begin
            scan_row_next = 6'd1;
            scan_col_next = 7'd0;
        end
        else if (cmd.scan_step)
        begin
            if (scan_col_reg == cols_c - 7'd1)
            begin
                scan_col_next = 7'd0;
                scan_row_next = scan_row_reg + 6'd1;
            end
            else
            begin
                scan_col_next = scan_col_reg + 7'd1;
            end
        end
    end

    // Fill counter for the reset pass and for clear.
    assign fill_last = (fill_cnt_reg == LAST_ADDR);

    always_comb
    begin
        fill_cnt_next = fill_cnt_reg;
        if (cmd.fill_step)
        begin
            fill_cnt_next = fill_last ? '0 : fill_cnt_reg + 1'b1;
        end
    end

    // Store port selection.
    always_comb
    begin
        mem_raddr = cmd.scan_step ? twcw_pkg::cell_addr(scan_row_reg, scan_col_reg)
                                  : twcw_pkg::cell_addr({1'b0, request.read_row},
                                                        request.read_col);
        mem_we    = 1'b0;
        mem_waddr = put_addr;
        mem_wdata = put_cell;
        if (cmd.fill_step)
        begin
            mem_we    = 1'b1;
            mem_waddr = fill_cnt_reg;
            mem_wdata = cmd.fill_reset ? {twcw_pkg::RESET_COLOR, twcw_pkg::CH_SPACE}
                                       : blank_cell;
        end
        else if (wr_pend_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = wr_dest_reg;
            mem_wdata = wr_blank_reg ? blank_cell : rdata_reg;
        end
        else if (cmd.exec && (item_reg.operation == twcw_pkg::OP_PUT) && put_we)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            content_cols_reg <= 7'd78;
            content_rows_reg <= 6'd23;
            text_color_reg   <= 8'd15;
            cursor_row_reg   <= 5'd0;
            cursor_col_reg   <= 7'd0;
            done_reg         <= 1'b0;
            wr_pend_reg      <= 1'b0;
            fill_cnt_reg     <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    twcw_pkg::CFG_COLS:  content_cols_reg <= cfg_data[6:0];
                    twcw_pkg::CFG_ROWS:  content_rows_reg <= cfg_data[5:0];
                    twcw_pkg::CFG_COLOR: text_color_reg   <= cfg_data;
                    default:             content_cols_reg <= content_cols_reg;
                endcase
            end
            cursor_row_reg <= cursor_row_next;
            cursor_col_reg <= cursor_col_next;
            done_reg       <= cmd.emit;
            wr_pend_reg    <= cmd.scan_step;
            fill_cnt_reg   <= fill_cnt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= request;
        end
        scrolled_reg  <= scrolled_next;
        data_reg      <= data_next;
        scan_row_reg  <= scan_row_next;
        scan_col_reg  <= scan_col_next;
        wr_blank_reg  <= (scan_row_reg == rows_c);
        wr_dest_reg   <= twcw_pkg::cell_addr(scan_row_reg - 6'd1, scan_col_reg);
    end

    assign status.op          = item_reg.operation;
    assign status.need_scroll = need_scroll;
    assign status.scan_last   = scan_last;
    assign status.fill_last   = fill_last;

    assign result.cursor_row = cursor_row_reg;
    assign result.cursor_col = cursor_col_reg;
    assign result.scrolled   = scrolled_reg;
    assign result.cell_data  = data_reg;
    assign done              = done_reg;

    // A result strobe lasts a single cycle.
    `TWCW_ASSERT(a_done_single, done_reg |=> !done_reg, "result strobe held for two cycles")
    // A delayed scroll write never meets another writer.
    `TWCW_ASSERT(a_pend_alone, wr_pend_reg |-> !(cmd.exec || cmd.fill_step), "scroll write collides with another store write")
    // After a put the cursor row lies inside the window.
    `TWCW_ASSERT(a_put_row_in_window, (cmd.exec && (item_reg.operation == twcw_pkg::OP_PUT)) |=> ({1'b0, cursor_row_reg} < rows_c), "cursor row left the window after a put")

endmodule
